// ===== hdl/tmaf_pkg.sv =====
// ----------------------------------------------------------------------------
// tmaf_pkg
// Shared types and constants of the trimmed mean converter filter.
// ----------------------------------------------------------------------------
package tmaf_pkg;

   // default configuration
   localparam int CHANNELS_DEF      = 8;
   localparam int HISTORY_DEPTH_DEF = 6;

   // fixed field widths
   localparam int CHANNEL_W = 3;
   localparam int SAMPLE_W  = 10;

   // trimmed sum is scaled down by this shift and clipped to the sample range
   localparam int                TRIM_SHIFT = 2;
   localparam logic [SAMPLE_W-1:0] AVG_MAX  = 10'd1023;

   // operations of the shared accumulate unit
   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_FIRST,
      ACC_ADD,
      ACC_SUB_HI,
      ACC_SUB_LO
   } acc_op_type;

   // control from the sequencer to the accumulate unit
   typedef struct packed {
      acc_op_type op;
      logic       entry_valid;
   } acc_ctrl_type;

endpackage

// ===== hdl/tmaf_ram.sv =====
// ----------------------------------------------------------------------------
// tmaf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tmaf_ram #(
   parameter int WIDTH = tmaf_pkg::SAMPLE_W,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tmaf_acc.sv =====
// ----------------------------------------------------------------------------
// tmaf_acc
// Shared accumulate unit: one adder and a max/min compare, stepped by the
// sequencer over the history entries of one channel, then trimmed.
// ----------------------------------------------------------------------------
module tmaf_acc #(
   parameter int HISTORY_DEPTH = tmaf_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                          clock,
   input  tmaf_pkg::acc_ctrl_type        ctrl,
   input  logic [tmaf_pkg::SAMPLE_W-1:0] rd_data,
   output logic [tmaf_pkg::SAMPLE_W-1:0] average
);

   localparam int SAMPLE_W = tmaf_pkg::SAMPLE_W;
   localparam int SUM_W    = $clog2(HISTORY_DEPTH * (1 << SAMPLE_W));
   localparam int SH_W     = SUM_W - tmaf_pkg::TRIM_SHIFT;

   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] hi_ff, hi_in;
   logic [SAMPLE_W-1:0] lo_ff, lo_in;
   logic [SAMPLE_W-1:0] entry;
   logic [SUM_W-1:0]    operand_a;
   logic [SUM_W-1:0]    operand_b;
   logic                carry;
   logic [SH_W-1:0]     scaled;

   // never written entries read as zero
   assign entry = ctrl.entry_valid ? rd_data : '0;

   // operand select for the shared adder
   always_comb begin
      operand_a = sum_ff;
      operand_b = '0;
      carry     = 1'b0;
      case (ctrl.op)
         tmaf_pkg::ACC_FIRST: begin
            operand_a = '0;
            operand_b = SUM_W'(entry);
         end
         tmaf_pkg::ACC_ADD: begin
            operand_b = SUM_W'(entry);
         end
         tmaf_pkg::ACC_SUB_HI: begin
            operand_b = ~SUM_W'(hi_ff);
            carry     = 1'b1;
         end
         tmaf_pkg::ACC_SUB_LO: begin
            operand_b = ~SUM_W'(lo_ff);
            carry     = 1'b1;
         end
         default: begin
            operand_a = sum_ff;
         end
      endcase
   end

   // next sum and extremes
   always_comb begin
      sum_in = sum_ff;
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      case (ctrl.op)
         tmaf_pkg::ACC_FIRST: begin
            sum_in = operand_a + operand_b + SUM_W'(carry);
            hi_in  = entry;
            lo_in  = entry;
         end
         tmaf_pkg::ACC_ADD: begin
            sum_in = operand_a + operand_b + SUM_W'(carry);
            hi_in  = (entry > hi_ff) ? entry : hi_ff;
            lo_in  = (entry < lo_ff) ? entry : lo_ff;
         end
         tmaf_pkg::ACC_SUB_HI, tmaf_pkg::ACC_SUB_LO: begin
            sum_in = operand_a + operand_b + SUM_W'(carry);
         end
         default: begin
            sum_in = sum_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
   end

   // scale and clip to the sample range
   assign scaled  = sum_ff[SUM_W-1:tmaf_pkg::TRIM_SHIFT];
   assign average = (scaled > SH_W'(tmaf_pkg::AVG_MAX)) ? tmaf_pkg::AVG_MAX
                                                         : scaled[SAMPLE_W-1:0];

endmodule

// ===== hdl/trimmed_mean_adc_filter_core.sv =====
// A new transfer is taken only while the sequencer is idle, so an item is not
// accepted before the previous result has gone into the output register; the
// history is read one entry per cycle into the shared accumulate unit, followed
// by two trim steps (max, then min) and the output load, which waits while the
// result side stalls a held result. Reset clears the history through per-entry
// valid bits and sets the history position to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
// trimmed_mean_adc_filter_core
// Per-channel converter sample history; an in-range transfer stores its sample
// and gets its history sum less max and min, shifted right by 2; others get zero.
// ----------------------------------------------------------------------------
module trimmed_mean_adc_filter_core #(
   parameter int CHANNELS      = tmaf_pkg::CHANNELS_DEF,
   parameter int HISTORY_DEPTH = tmaf_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tmaf_pkg::CHANNEL_W-1:0] req_channel,
   input  logic [tmaf_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                           req_end_of_round,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tmaf_pkg::CHANNEL_W-1:0] rsp_channel_out,
   output logic [tmaf_pkg::SAMPLE_W-1:0]  rsp_average
);

   localparam int CHANNEL_W = tmaf_pkg::CHANNEL_W;
   localparam int SAMPLE_W  = tmaf_pkg::SAMPLE_W;
   localparam int CMP_W     = CHANNEL_W + 2;
   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_W    = $clog2(HISTORY_DEPTH);
   localparam int ADDR_W    = CH_W + SLOT_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_LAST,
      S_SUB_HI,
      S_SUB_LO,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [SLOT_W-1:0]      pos_ff, pos_in;
   logic [SLOT_W-1:0]      count_ff, count_in;
   logic [CH_W-1:0]        ch_idx_ff, ch_idx_in;
   logic [CHANNEL_W-1:0]   ch_ff, ch_in;
   logic                   ch_ok_ff, ch_ok_in;
   logic [MEM_DEPTH-1:0]   valid_ff, valid_in;
   logic                   entry_valid_ff, entry_valid_in;
   logic                   out_valid_ff, out_valid_in;
   logic [CHANNEL_W-1:0]   out_channel_ff, out_channel_in;
   logic [SAMPLE_W-1:0]    out_average_ff, out_average_in;

   logic                   accept;
   logic                   req_ch_ok;
   logic [CMP_W-1:0]       req_ch_ext;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   rd_en;
   logic                   wr_en;
   logic                   out_load;
   logic [SAMPLE_W-1:0]    rd_data;
   logic [SAMPLE_W-1:0]    average;
   tmaf_pkg::acc_ctrl_type acc_ctrl;

   // input transfer and channel range check
   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign req_ch_ext = CMP_W'(req_channel);
   assign req_ch_ok  = (req_ch_ext < CMP_W'(CHANNELS));

   // history store: write at an in-range transfer, read one entry per cycle
   assign wr_en   = accept && req_ch_ok;
   assign wr_addr = {req_ch_ext[CH_W-1:0], pos_ff};
   assign rd_en   = (state_ff == S_READ);
   assign rd_addr = {ch_idx_ff, count_ff};

   tmaf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MEM_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_sample),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // accumulate unit operation per sequencer step
   always_comb begin
      acc_ctrl.entry_valid = entry_valid_ff;
      acc_ctrl.op          = tmaf_pkg::ACC_HOLD;
      case (state_ff)
         S_READ: begin
            if (count_ff == SLOT_W'(1)) begin
               acc_ctrl.op = tmaf_pkg::ACC_FIRST;
            end else if (count_ff != '0) begin
               acc_ctrl.op = tmaf_pkg::ACC_ADD;
            end
         end
         S_LAST:   acc_ctrl.op = tmaf_pkg::ACC_ADD;
         S_SUB_HI: acc_ctrl.op = tmaf_pkg::ACC_SUB_HI;
         S_SUB_LO: acc_ctrl.op = tmaf_pkg::ACC_SUB_LO;
         default:  acc_ctrl.op = tmaf_pkg::ACC_HOLD;
      endcase
   end

   tmaf_acc #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_acc (
      .clock   (clock),
      .ctrl    (acc_ctrl),
      .rd_data (rd_data),
      .average (average)
   );

   // output register is free when empty or being taken
   assign out_load = (state_ff == S_DONE) && (!out_valid_ff || !rsp_stall);

   // sequencer next state
   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      count_in       = count_ff;
      ch_idx_in      = ch_idx_ff;
      ch_in          = ch_ff;
      ch_ok_in       = ch_ok_ff;
      valid_in       = valid_ff;
      entry_valid_in = entry_valid_ff;
      out_valid_in   = out_valid_ff && rsp_stall;
      out_channel_in = out_channel_ff;
      out_average_in = out_average_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ch_in     = req_channel;
               ch_idx_in = req_ch_ext[CH_W-1:0];
               ch_ok_in  = req_ch_ok;
               count_in  = '0;
               if (req_ch_ok) begin
                  valid_in[wr_addr] = 1'b1;
               end
               if (req_end_of_round) begin
                  pos_in = (pos_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                                                                   : pos_ff + 1'b1;
               end
               state_in = req_ch_ok ? S_READ : S_DONE;
            end
         end
         S_READ: begin
            entry_valid_in = valid_ff[rd_addr];
            if (count_ff == SLOT_W'(HISTORY_DEPTH - 1)) begin
               count_in = '0;
               state_in = S_LAST;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         S_LAST:   state_in = S_SUB_HI;
         S_SUB_HI: state_in = S_SUB_LO;
         S_SUB_LO: state_in = S_DONE;
         S_DONE: begin
            if (out_load) begin
               out_valid_in   = 1'b1;
               out_channel_in = ch_ff;
               out_average_in = ch_ok_ff ? average : '0;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         count_ff     <= '0;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
      ch_idx_ff      <= ch_idx_in;
      ch_ff          <= ch_in;
      ch_ok_ff       <= ch_ok_in;
      entry_valid_ff <= entry_valid_in;
      out_channel_ff <= out_channel_in;
      out_average_ff <= out_average_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_channel_out = out_channel_ff;
   assign rsp_average     = out_average_ff;

`ifndef NO_ASSERTIONS
   // history position stays inside the history depth
   a_pos_range : assert property (@(posedge clock) disable iff (reset)
      {1'b0, pos_ff} < (SLOT_W + 1)'(HISTORY_DEPTH))
      else $error("history position out of range");

   // read counter stays inside the history depth while reading
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> ({1'b0, count_ff} < (SLOT_W + 1)'(HISTORY_DEPTH)))
      else $error("read counter out of range");

   // a channel outside the range never marks a history entry
   a_bad_channel : assert property (@(posedge clock) disable iff (reset)
      (accept && !req_ch_ok) |=> ($stable(valid_ff) && state_ff == S_DONE))
      else $error("out of range channel touched the history");

   // a new result never overwrites one that is still held
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !out_load)
      else $error("result overwritten while stalled");

   // a transfer in range starts the history read
   a_start_read : assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch_ok) |=> (state_ff == S_READ && count_ff == '0))
      else $error("history read did not start");
`endif

endmodule
